@@ rtl/core/lcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types, constants and keyword tables of the line command recognizer.
// ----------------------------------------------------------------------------
package lcr_pkg;

	localparam int LCR_LINE_BYTES_DEF = 64;
	localparam int LCR_QUEUE_DEPTH    = 2;
	localparam int LCR_KIND_COUNT     = 7;
	localparam int LCR_PREFIX_LEN     = 4;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		EV_ACK_UP  = 3'd0,
		EV_ACK_CFG = 3'd1,
		EV_ACK_HB  = 3'd2,
		EV_ACK_CMD = 3'd3,
		EV_CMD     = 3'd4,
		EV_RUN     = 3'd5,
		EV_IDLE    = 3'd6
	} lcr_event_t;

	// number parser phases
	typedef enum logic [3:0] {
		NP_SKIP  = 4'b0001,
		NP_SIGN  = 4'b0010,
		NP_DIGIT = 4'b0100,
		NP_DONE  = 4'b1000
	} lcr_num_phase_t;

	// classified byte as it travels through the queue
	typedef struct packed {
		logic       nl;
		logic       nul;
		logic       space;
		logic       sign;
		logic       minus;
		logic       digit;
		logic [3:0] digit_val;
		logic [7:0] data;
	} lcr_word_t;

	// keyword text, left justified, zero padded
	function automatic logic [63:0] kw_text(input logic [2:0] k);
		logic [63:0] s;
		s = '0;
		unique case (k)
			EV_ACK_UP:  s = {"ACK_UP", 16'h0};
			EV_ACK_CFG: s = {"ACK_CFG", 8'h0};
			EV_ACK_HB:  s = {"ACK_HB", 16'h0};
			EV_ACK_CMD: s = {"ACK_CMD", 8'h0};
			EV_CMD:     s = {"CMD:", 32'h0};
			EV_RUN:     s = {"RUN", 40'h0};
			EV_IDLE:    s = {"IDLE", 32'h0};
			default:    s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [63:0] s;
		logic [5:0]  lsb;
		s   = kw_text(k);
		lsb = {3'd7 - p, 3'b000};
		return s[lsb +: 8];
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] n;
		n = '0;
		unique case (k)
			EV_ACK_UP:  n = 3'd6;
			EV_ACK_CFG: n = 3'd7;
			EV_ACK_HB:  n = 3'd6;
			EV_ACK_CMD: n = 3'd7;
			EV_CMD:     n = 3'd4;
			EV_RUN:     n = 3'd3;
			EV_IDLE:    n = 3'd4;
			default:    n = '0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/core/lcr_byte_if.sv @@
// ----------------------------------------------------------------------------
// lcr_byte_if
// Received byte channel: valid/ready handshake with one character.
// ----------------------------------------------------------------------------
interface lcr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/lcr_event_if.sv @@
// ----------------------------------------------------------------------------
// lcr_event_if
// Recognized event channel: valid/ready handshake with kind and node id.
// ----------------------------------------------------------------------------
interface lcr_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] node_id;

	modport source (output valid, output event_kind, output node_id, input ready);
	modport sink   (input valid, input event_kind, input node_id, output ready);
endinterface

@@ rtl/core/lcr_front.sv @@
// ----------------------------------------------------------------------------
// lcr_front
// Accepts received bytes, drops carriage returns, classifies the rest.
// ----------------------------------------------------------------------------
module lcr_front
	import lcr_pkg::*;
(
	lcr_byte_if.sink  rx,
	input  logic      full,
	output logic      push,
	output lcr_word_t word
);

	logic [7:0] b;

	assign b        = rx.rx_byte;
	assign rx.ready = !full;
	// CR is taken off the link but never queued
	assign push     = rx.valid && !full && (b != CH_CR);

	always_comb begin
		word           = '0;
		word.data      = b;
		word.nl        = (b == CH_LF);
		word.nul       = (b == CH_NUL);
		word.space     = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
		word.sign      = (b == CH_PLUS) || (b == CH_MINUS);
		word.minus     = (b == CH_MINUS);
		word.digit     = (b >= CH_ZERO) && (b <= CH_NINE);
		word.digit_val = 4'(b - CH_ZERO);
	end

endmodule

@@ rtl/core/lcr_queue.sv @@
// ----------------------------------------------------------------------------
// lcr_queue
// Short register queue between the classifier and the line engine.
// ----------------------------------------------------------------------------
module lcr_queue
	import lcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lcr_word_t push_word,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output lcr_word_t head
);

	localparam int PTR_W = (LCR_QUEUE_DEPTH > 1) ? $clog2(LCR_QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(LCR_QUEUE_DEPTH + 1);

	lcr_word_t          slot_q [LCR_QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(LCR_QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LCR_QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LCR_QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue pop did not shrink count");

endmodule

@@ rtl/core/lcr_back.sv @@
// ----------------------------------------------------------------------------
// lcr_back
// Line engine: keyword match flags, CMD: number parser, event register.
// ----------------------------------------------------------------------------
module lcr_back
	import lcr_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = LCR_LINE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          word_valid,
	input  lcr_word_t     word,
	output logic          pop,
	lcr_event_if.source   ev
);

	localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
	localparam int KC    = LCR_KIND_COUNT;

	logic [LEN_W-1:0]  len_q;
	logic [KC-1:0]     alive_q;
	logic              ended_q;
	lcr_num_phase_t    phase_q;
	logic              neg_q;
	logic [7:0]        value_q;

	logic              out_v_q;
	logic [2:0]        kind_q;
	logic [7:0]        id_q;

	logic [LEN_W-1:0]  len_d;
	logic [KC-1:0]     alive_d;
	logic              ended_d;
	lcr_num_phase_t    phase_d;
	logic              neg_d;
	logic [7:0]        value_d;
	logic              emit;
	logic [2:0]        emit_kind;
	logic [7:0]        emit_id;

	logic [KC-1:0]     short_mask;
	logic [KC-1:0]     final_alive;
	logic              len_lt8;
	logic              len_ge_prefix;
	logic [2:0]        p3;
	logic              take;

	assign take = !out_v_q || ev.ready;
	assign pop  = word_valid && take;

	assign len_lt8       = ({1'b0, len_q} < (LEN_W + 1)'(8));
	assign len_ge_prefix = ({1'b0, len_q} >= (LEN_W + 1)'(LCR_PREFIX_LEN));
	assign p3            = len_q[2:0];

	// keywords longer than what the line holds so far
	always_comb begin
		for (int k = 0; k < KC; k++) begin
			short_mask[k] = len_lt8 && (p3 < kw_len(3'(k)));
		end
	end

	assign final_alive = ended_q ? alive_q : (alive_q & ~short_mask);

	always_comb begin
		len_d     = len_q;
		alive_d   = alive_q;
		ended_d   = ended_q;
		phase_d   = phase_q;
		neg_d     = neg_q;
		value_d   = value_q;
		emit      = 1'b0;
		emit_kind = '0;
		emit_id   = '0;
		if (word.nl) begin
			if (len_q != '0) begin
				// lowest matching kind wins
				for (int k = KC - 1; k >= 0; k--) begin
					if (final_alive[k]) begin
						emit      = 1'b1;
						emit_kind = 3'(k);
					end
				end
				if (emit && (emit_kind == EV_CMD)) begin
					emit_id = neg_q ? 8'(8'd0 - value_q) : value_q;
				end
				len_d   = '0;
				alive_d = '1;
				ended_d = 1'b0;
				phase_d = NP_SKIP;
				neg_d   = 1'b0;
				value_d = '0;
			end
		end else if (len_q >= LEN_W'(LINE_BUFFER_BYTES - 1)) begin
			// overflow: line dropped along with this byte
			len_d   = '0;
			alive_d = '1;
			ended_d = 1'b0;
			phase_d = NP_SKIP;
			neg_d   = 1'b0;
			value_d = '0;
		end else begin
			len_d = len_q + 1'b1;
			if (!ended_q) begin
				if (word.nul) begin
					ended_d = 1'b1;
					alive_d = alive_q & ~short_mask;
				end else begin
					for (int k = 0; k < KC; k++) begin
						if (short_mask[k]) begin
							alive_d[k] = alive_q[k] && (kw_char(3'(k), p3) == word.data);
						end else begin
							alive_d[k] = alive_q[k] && (k == int'(EV_CMD));
						end
					end
					if (len_ge_prefix) begin
						priority if ((phase_q == NP_SKIP) && word.space) begin
							phase_d = NP_SKIP;
						end else if ((phase_q == NP_SKIP) && word.sign) begin
							neg_d   = word.minus;
							phase_d = NP_SIGN;
						end else if (phase_q != NP_DONE) begin
							if (word.digit) begin
								value_d = 8'({value_q, 3'b000} + {value_q, 1'b0}
									+ {4'd0, word.digit_val});
								phase_d = NP_DIGIT;
							end else begin
								phase_d = NP_DONE;
							end
						end else begin
							phase_d = phase_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			alive_q <= '1;
			ended_q <= 1'b0;
			phase_q <= NP_SKIP;
			neg_q   <= 1'b0;
			value_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				len_q   <= len_d;
				alive_q <= alive_d;
				ended_q <= ended_d;
				phase_q <= phase_d;
				neg_q   <= neg_d;
				value_q <= value_d;
			end
			if (take) begin
				out_v_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit && take) begin
			kind_q <= emit_kind;
			id_q   <= emit_id;
		end
	end

	assign ev.valid      = out_v_q;
	assign ev.event_kind = kind_q;
	assign ev.node_id    = id_q;

	a_id_only_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((id_q == 8'd0) || (kind_q == EV_CMD)))
		else $error("node id set on a non-command event");

	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && word.nl) |=> (len_q == '0))
		else $error("line not cleared after newline");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_BUFFER_BYTES - 1))
		else $error("line length past buffer size");

endmodule

@@ rtl/core/line_command_recognizer.sv @@
// ----------------------------------------------------------------------------
// line_command_recognizer
// Assembles received bytes into lines and reports recognized commands.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------
//  rx      | in  | valid / ready  | rx_byte[7:0]
//  ev      | out | valid / ready  | event_kind[2:0], node_id[7:0]
//
// One byte per cycle sustained while ev does not stall; the event is registered
// at the edge that pops its newline from the queue, so the newline passes the
// queue register and then the event register before ev.valid rises.
// The line engine updates all match flags and the number parser together for
// each byte it pops, so a new byte can follow at once while ev is not stalled.
// Reset (arst_n low) empties the queue, clears the line and drops any event.
// A stalled ev holds its event; the queue keeps taking bytes until it fills
// (two words), then rx.ready drops. Carriage returns never enter the queue.
//
module line_command_recognizer
	import lcr_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = LCR_LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lcr_byte_if.sink    rx,
	lcr_event_if.source ev
);

	// front -> queue
	logic      q_push;
	lcr_word_t q_in;
	logic      q_full;

	// queue -> back
	logic      q_pop;
	logic      q_valid;
	lcr_word_t q_head;

	// classify each byte and drop CR
	lcr_front u_front (
		.rx   (rx),
		.full (q_full),
		.push (q_push),
		.word (q_in)
	);

	// decoupling queue: lets the link side keep going while ev stalls
	lcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// line engine with registered event output
	lcr_back #(
		.LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (q_valid),
		.word       (q_head),
		.pop        (q_pop),
		.ev         (ev)
	);

endmodule

@@ verif/lcr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcr_checker
// Watches both channels of the line command recognizer, predicts the events
// from every accepted byte and compares each accepted event field by field.
// ----------------------------------------------------------------------------
module lcr_checker
	import lcr_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = LCR_LINE_BYTES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	lcr_byte_if   rx,
	lcr_event_if  ev,
	output int    fail_count,
	output int    events_owed
);

	typedef struct packed {
		lcr_event_t kind;
		logic [7:0] node;
	} cmd_event_t;

	cmd_event_t     awaited [$];

	// line state of the predictor
	int             line_len;
	logic [6:0]     alive;
	logic           text_done;
	lcr_num_phase_t num_phase;
	logic           num_neg;
	logic [7:0]     num_acc;
	int             errors = 0;

	function automatic string keyword_of(input int k);
		case (k)
			EV_ACK_UP:  return "ACK_UP";
			EV_ACK_CFG: return "ACK_CFG";
			EV_ACK_HB:  return "ACK_HB";
			EV_ACK_CMD: return "ACK_CMD";
			EV_CMD:     return "CMD:";
			EV_RUN:     return "RUN";
			default:    return "IDLE";
		endcase
	endfunction

	function void restart_line();
		line_len  = 0;
		alive     = '1;
		text_done = 1'b0;
		num_phase = NP_SKIP;
		num_neg   = 1'b0;
		num_acc   = '0;
	endfunction

	// atoi-style parse of the text after CMD:
	function void feed_number(input logic [7:0] b);
		logic digit;
		logic blank;
		digit = (b >= CH_ZERO) && (b <= CH_NINE);
		blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
		if (num_phase == NP_SKIP) begin
			if (blank)
				return;
			if ((b == CH_PLUS) || (b == CH_MINUS)) begin
				num_neg   = (b == CH_MINUS);
				num_phase = NP_SIGN;
				return;
			end
		end
		if (num_phase != NP_DONE) begin
			if (digit) begin
				num_acc   = num_acc * 8'd10 + 8'(b - CH_ZERO);
				num_phase = NP_DIGIT;
			end else begin
				num_phase = NP_DONE;
			end
		end
	endfunction

	function void take_char(input logic [7:0] b);
		int         k;
		logic [6:0] live;
		logic       found;
		logic       keep;
		string      kw;
		cmd_event_t hit;
		if (b == CH_CR)
			return;
		if (b == CH_LF) begin
			if (line_len == 0)
				return;
			live = alive;
			// a line shorter than a keyword cannot match it unless a NUL ended it
			if (!text_done)
				for (k = 0; k < LCR_KIND_COUNT; k++) begin
					kw = keyword_of(k);
					if (line_len < kw.len())
						live[k] = 1'b0;
				end
			found = 1'b0;
			for (k = 0; k < LCR_KIND_COUNT; k++) begin
				if (live[k] && !found) begin
					found    = 1'b1;
					hit.kind = lcr_event_t'(k);
					hit.node = '0;
					if (k == EV_CMD)
						hit.node = num_neg ? 8'd0 - num_acc : num_acc;
					awaited.push_back(hit);
				end
			end
			restart_line();
			return;
		end
		// full line: the byte is dropped and the line starts over
		if (line_len >= LINE_BUFFER_BYTES - 1) begin
			restart_line();
			return;
		end
		if (!text_done) begin
			if (b == CH_NUL) begin
				text_done = 1'b1;
				for (k = 0; k < LCR_KIND_COUNT; k++) begin
					kw = keyword_of(k);
					if (line_len < kw.len())
						alive[k] = 1'b0;
				end
			end else begin
				for (k = 0; k < LCR_KIND_COUNT; k++) begin
					kw = keyword_of(k);
					if (line_len < kw.len())
						keep = (kw[line_len] == b);
					else
						keep = (k == EV_CMD);
					if (!keep)
						alive[k] = 1'b0;
				end
				if (line_len >= LCR_PREFIX_LEN)
					feed_number(b);
			end
		end
		line_len++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_line();
			awaited.delete();
			events_owed <= 0;
		end else begin
			if (ev.valid && ev.ready) begin
				if (awaited.size() == 0) begin
					$error("unexpected event: event_kind %0d node_id %0d",
						ev.event_kind, ev.node_id);
					errors++;
				end else begin
					if (ev.event_kind !== awaited[0].kind) begin
						$error("event_kind expected %0d actual %0d",
							awaited[0].kind, ev.event_kind);
						errors++;
					end
					if (ev.node_id !== awaited[0].node) begin
						$error("node_id expected %0d actual %0d",
							awaited[0].node, ev.node_id);
						errors++;
					end
					void'(awaited.pop_front());
				end
			end
			if (rx.valid && rx.ready)
				take_char(rx.rx_byte);
			events_owed <= awaited.size();
			fail_count  <= errors;
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the line command recognizer: a directed set of
// lines, then random lines under three idling patterns, and gives the verdict
// from the checker's failure count and its count of events still owed.
// ----------------------------------------------------------------------------
module tb_top;
	import lcr_pkg::*;

	localparam int LINE_BYTES   = LCR_LINE_BYTES_DEF;
	localparam int RANDOM_BYTES = 1350;
	localparam int CYCLE_LIMIT  = 300000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   events_owed;
	int   cycle_count;
	int   bytes_sent;
	int   src_idle_pct;
	int   snk_idle_pct;

	lcr_byte_if  rx ();
	lcr_event_if ev ();

	line_command_recognizer #(
		.LINE_BUFFER_BYTES(LINE_BYTES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.ev     (ev)
	);

	lcr_checker #(
		.LINE_BUFFER_BYTES(LINE_BYTES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.ev          (ev),
		.fail_count  (fail_count),
		.events_owed (events_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// event sink: ready drops at random per the current idle percentage
	always @(posedge clk) begin
		ev.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	// Present one word and hold it until the handshake takes it. Random idle
	// cycles before the word; valid is left high so back-to-back words flow.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		if (b != CH_CR)
			bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// text with a stray carriage return now and then; CRs never change a line
	task automatic send_mixed(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			if ($urandom_range(15) == 0)
				send_byte(CH_CR);
			send_byte(s[i]);
		end
	endtask

	function automatic string random_keyword();
		case ($urandom_range(5))
			0:       return "ACK_UP";
			1:       return "ACK_CFG";
			2:       return "ACK_HB";
			3:       return "ACK_CMD";
			4:       return "RUN";
			default: return "IDLE";
		endcase
	endfunction

	// the part after CMD: -- white space, sign, digits and trailing junk
	task automatic send_node_number();
		int i;
		int n;
		n = $urandom_range(2);
		for (i = 0; i < n; i++)
			case ($urandom_range(3))
				0:       send_byte(CH_SPACE);
				1:       send_byte(CH_TAB);
				2:       send_byte(8'h0b);   // vertical tab
				default: send_byte(8'h0c);   // form feed
			endcase
		case ($urandom_range(5))
			0: send_byte(CH_PLUS);
			1: send_byte(CH_MINUS);
			2: begin
				send_byte(CH_PLUS);
				send_byte(CH_MINUS);
			end
			default: ;
		endcase
		n = $urandom_range(5);
		for (i = 0; i < n; i++)
			send_byte(8'(CH_ZERO + $urandom_range(9)));
		if ($urandom_range(3) == 0)
			send_byte(8'($urandom_range(255)));
		if ($urandom_range(5) == 0)
			send_byte(8'(CH_ZERO + $urandom_range(9)));
	endtask

	task automatic send_random_line();
		int    pick;
		int    i;
		int    n;
		int    pos;
		string kw;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// exact keyword, sometimes with a NUL and junk after the text
			send_mixed(random_keyword());
			if ($urandom_range(3) == 0) begin
				send_byte(CH_NUL);
				n = $urandom_range(3);
				for (i = 0; i < n; i++)
					send_byte(8'($urandom_range(255)));
			end
		end else if (pick < 65) begin
			send_mixed("CMD:");
			send_node_number();
		end else if (pick < 80) begin
			// near miss: one char off, cut short, one extra or a NUL inside
			kw  = random_keyword();
			pos = $urandom_range(kw.len() - 1);
			case ($urandom_range(3))
				0: for (i = 0; i < kw.len(); i++)
					send_byte((i == pos) ? 8'($urandom_range(255)) : 8'(kw[i]));
				1: for (i = 0; i < pos; i++)
					send_byte(kw[i]);
				2: begin
					send_text(kw);
					send_byte(8'($urandom_range(32, 126)));
				end
				default: for (i = 0; i < kw.len(); i++) begin
					if (i == pos)
						send_byte(CH_NUL);
					send_byte(kw[i]);
				end
			endcase
		end else if (pick < 90) begin
			n = $urandom_range(12);
			for (i = 0; i < n; i++)
				send_byte(8'($urandom_range(255)));
		end else if (pick < 95) begin
			// around the line limit: the 64th byte clears the line
			n = $urandom_range(LINE_BYTES - 4, LINE_BYTES + 3);
			send_text("CMD:");
			for (i = 4; i < n; i++)
				send_byte(8'(CH_ZERO + $urandom_range(9)));
		end else if ($urandom_range(1) == 0) begin
			send_byte(CH_CR);
		end
		send_byte(CH_LF);
	endtask

	initial begin
		int i;
		arst_n       = 1'b0;
		rx.valid     = 1'b0;
		rx.rx_byte   = '0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		bytes_sent   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every keyword, number forms, empty lines, CR, NUL, limit
		send_text("ACK_UP\n");
		send_text("ACK_CFG\n");
		send_text("ACK_HB\n");
		send_text("ACK_CMD\n");
		send_text("RUN\n");
		send_text("IDLE\n");
		send_text("CMD:42\n");
		send_text("CMD: -7\n");
		send_text("CMD:+300\n");
		send_text("CMD:\n");
		send_text("CMD:x9\n");
		send_text("\n");
		send_text("\r\n");
		send_text("RU\rN\r\n");
		send_text("RUNX\n");
		send_text("ID");
		send_byte(CH_NUL);
		send_text("LE\n");
		send_text("IDLE");
		send_byte(CH_NUL);
		send_byte(8'hff);
		send_text("\n");
		send_byte(8'hff);
		send_byte(CH_LF);
		// a line of exactly the maximum length
		send_text("CMD:");
		for (i = 4; i < LINE_BYTES - 1; i++)
			send_byte(8'(CH_ZERO + (i % 10)));
		send_byte(CH_LF);
		// one byte past the maximum: dropped, line restarts
		for (i = 0; i < LINE_BYTES; i++)
			send_byte("A");
		send_text("RUN\n");

		// random lines: sender idles lightly, then the sink, then neither
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent < RANDOM_BYTES / 3) begin
				src_idle_pct = 10;
				snk_idle_pct = 74;
			end else if (bytes_sent < 2 * RANDOM_BYTES / 3) begin
				src_idle_pct = 74;
				snk_idle_pct = 10;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			send_random_line();
		end

		rx.valid <= 1'b0;
		snk_idle_pct = 0;
		@(posedge clk);
		while (events_owed != 0)
			@(posedge clk);
		// drain: let anything still in the queue come out before the verdict
		repeat (20) @(posedge clk);
		if ((fail_count == 0) && (events_owed == 0))
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
